// ===== rtl/qvu_pkg.sv =====
// Shared types and constants of the quaternion vector unit.
`timescale 1ns / 1ps
package qvu_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Operation codes.
  localparam logic [1:0] FUNC_ROTATE = 2'd0;
  localparam logic [1:0] FUNC_NORM_Q = 2'd1;
  localparam logic [1:0] FUNC_NORM_V = 2'd2;
  localparam logic [1:0] FUNC_LENGTH = 2'd3;

  // Sum of four squares is padded to an even width; its root takes ROOT_W bits.
  localparam int SUM_W  = 66;
  localparam int ROOT_W = 33;
  localparam int ROT_LAT = 5;
  localparam int DIV_LAT = ROOT_W + 2;
  localparam int NORM_LAT = 2 + ROOT_W + DIV_LAT;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic signed [31:0] res_w;
    logic [31:0]        magnitude;
  } out_t;

  // Operation and the components whose norm is taken, in x, y, z, w order.
  typedef struct packed {
    logic [1:0]       func;
    logic [3:0][31:0] comp;
  } norm_side_t;

endpackage

// ===== rtl/qvu_rot.sv =====
// Five-stage pipeline that rotates a vector by a quaternion.
`timescale 1ns / 1ps
module qvu_rot #(
  parameter int FRAC_BITS = qvu_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  qvu_pkg::in_t  in_data,
  output qvu_pkg::out_t out_data
);

  localparam int PW = 97;
  localparam int CW = 100;

  logic signed [31:0] u_in [3];
  logic signed [31:0] v_in [3];

  logic signed [31:0] u_r1 [3], u_r2 [3];
  logic signed [31:0] v_r1 [3], v_r2 [3], v_r3 [3], v_r4 [3];
  logic signed [63:0] pa_r1 [3], pb_r1 [3], pc_r1 [3];
  logic signed [63:0] t_r2 [3];
  logic signed [64:0] alo_r3 [3], blo_r3 [3];
  logic signed [63:0] ahi_r3 [3], bhi_r3 [3];
  logic signed [PW-1:0] pa_r4 [3], pb_r4 [3];
  logic signed [31:0] res_r5 [3];

  assign u_in[0] = in_data.quat_x;
  assign u_in[1] = in_data.quat_y;
  assign u_in[2] = in_data.quat_z;
  assign v_in[0] = in_data.vec_x;
  assign v_in[1] = in_data.vec_y;
  assign v_in[2] = in_data.vec_z;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    logic signed [63:0]   pa_nxt, pb_nxt, pc_nxt;
    logic signed [65:0]   acc;
    logic signed [63:0]   t_nxt;
    logic signed [64:0]   alo_nxt, blo_nxt;
    logic signed [63:0]   ahi_nxt, bhi_nxt;
    logic signed [PW-1:0] fa_nxt, fb_nxt;
    logic signed [CW-1:0] c_sum, c_shr;
    logic signed [31:0]   res_nxt;

    assign pa_nxt = u_in[J] * v_in[K];
    assign pb_nxt = u_in[K] * v_in[J];
    assign pc_nxt = in_data.quat_w * v_in[i];

    assign acc   = 66'(pa_r1[i]) - 66'(pb_r1[i]) + 66'(pc_r1[i]);
    assign t_nxt = 64'(acc >>> FRAC_BITS);

    // The 64-bit t is split into a signed upper and an unsigned lower half.
    assign alo_nxt = u_r2[J] * $signed({1'b0, t_r2[K][31:0]});
    assign ahi_nxt = u_r2[J] * $signed(t_r2[K][63:32]);
    assign blo_nxt = u_r2[K] * $signed({1'b0, t_r2[J][31:0]});
    assign bhi_nxt = u_r2[K] * $signed(t_r2[J][63:32]);

    assign fa_nxt = (PW'(ahi_r3[i]) <<< 32) + PW'(alo_r3[i]);
    assign fb_nxt = (PW'(bhi_r3[i]) <<< 32) + PW'(blo_r3[i]);

    assign c_sum = ((CW'(pa_r4[i]) - CW'(pb_r4[i])) <<< 1) + (CW'(v_r4[i]) <<< FRAC_BITS);
    assign c_shr = c_sum >>> FRAC_BITS;

    always_comb begin
      if ((&c_shr[CW-1:31]) || !(|c_shr[CW-1:31])) begin
        res_nxt = c_shr[31:0];
      end else if (c_shr[CW-1]) begin
        res_nxt = 32'sh8000_0000;
      end else begin
        res_nxt = 32'sh7FFF_FFFF;
      end
    end

    always_ff @(posedge clk) begin
      u_r1[i]   <= u_in[i];
      v_r1[i]   <= v_in[i];
      pa_r1[i]  <= pa_nxt;
      pb_r1[i]  <= pb_nxt;
      pc_r1[i]  <= pc_nxt;
      u_r2[i]   <= u_r1[i];
      v_r2[i]   <= v_r1[i];
      t_r2[i]   <= t_nxt;
      v_r3[i]   <= v_r2[i];
      alo_r3[i] <= alo_nxt;
      ahi_r3[i] <= ahi_nxt;
      blo_r3[i] <= blo_nxt;
      bhi_r3[i] <= bhi_nxt;
      v_r4[i]   <= v_r3[i];
      pa_r4[i]  <= fa_nxt;
      pb_r4[i]  <= fb_nxt;
      res_r5[i] <= res_nxt;
    end
  end

  always_comb begin
    out_data.res_x     = res_r5[0];
    out_data.res_y     = res_r5[1];
    out_data.res_z     = res_r5[2];
    out_data.res_w     = '0;
    out_data.magnitude = '0;
  end

endmodule

// ===== rtl/qvu_sqrt.sv =====
// Pipelined floor square root, one root bit per stage.
`timescale 1ns / 1ps
module qvu_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  qvu_pkg::norm_side_t        in_side,
  input  logic [qvu_pkg::SUM_W-1:0]  in_sum,
  output logic                       out_valid,
  output qvu_pkg::norm_side_t        out_side,
  output logic [qvu_pkg::ROOT_W-1:0] out_root
);

  localparam int N  = qvu_pkg::ROOT_W;
  localparam int XW = qvu_pkg::SUM_W;
  localparam int RW = 36;

  typedef struct packed {
    qvu_pkg::norm_side_t side;
    logic [XW-1:0]       x;
    logic [RW-1:0]       rem;
    logic [N-1:0]        root;
  } sq_stage_t;

  logic [N:0]  vld_r;
  sq_stage_t   st_r [0:N];

  assign vld_r[0]    = in_valid;
  assign st_r[0]     = '{side: in_side, x: in_sum, rem: '0, root: '0};

  for (genvar s = 0; s < N; s++) begin : g_step
    logic [RW-1:0] rem_sh, trial;
    logic          ge;
    sq_stage_t     st_nxt;

    assign rem_sh = {st_r[s].rem[RW-3:0], st_r[s].x[XW-1 -: 2]};
    assign trial  = RW'({st_r[s].root, 2'b01});
    assign ge     = rem_sh >= trial;

    always_comb begin
      st_nxt      = st_r[s];
      st_nxt.x    = {st_r[s].x[XW-3:0], 2'b00};
      st_nxt.rem  = ge ? rem_sh - trial : rem_sh;
      st_nxt.root = {st_r[s].root[N-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
      st_r[s+1] <= st_nxt;
    end
  end

  assign out_valid = vld_r[N];
  assign out_side  = st_r[N].side;
  assign out_root  = st_r[N].root;

endmodule

// ===== rtl/qvu_div.sv =====
// Four-lane pipelined divider that normalizes components by the root.
`timescale 1ns / 1ps
module qvu_div #(
  parameter int FRAC_BITS = qvu_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  qvu_pkg::norm_side_t        in_side,
  input  logic [qvu_pkg::ROOT_W-1:0] in_root,
  output logic                       out_valid,
  output logic [1:0]                 out_func,
  output qvu_pkg::out_t              out_data
);

  localparam int N  = qvu_pkg::ROOT_W;
  localparam int DW = 32 + FRAC_BITS;
  localparam int HW = DW - N;

  typedef struct packed {
    logic [N-1:0] rem;
    logic [N-1:0] quo;
    logic [N-1:0] dlo;
    logic         ovf;
    logic         neg;
  } lane_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [N-1:0]     root;
    lane_t [3:0]      lane;
  } dv_stage_t;

  logic [N:0] vld_r;
  dv_stage_t  st_r [0:N];
  dv_stage_t  entry_nxt;

  // Entry stage: magnitudes, the scaled dividend and the early overflow test.
  always_comb begin
    logic [31:0]   mag;
    logic [DW-1:0] dvd;
    logic [HW-1:0] hi;
    entry_nxt.func = in_side.func;
    entry_nxt.root = in_root;
    for (int l = 0; l < 4; l++) begin
      mag = in_side.comp[l][31] ? 32'(~in_side.comp[l] + 32'd1) : in_side.comp[l];
      dvd = {mag, {FRAC_BITS{1'b0}}};
      hi  = dvd[DW-1:N];
      entry_nxt.lane[l].ovf = N'(hi) >= in_root;
      entry_nxt.lane[l].rem = entry_nxt.lane[l].ovf ? '0 : N'(hi);
      entry_nxt.lane[l].dlo = dvd[N-1:0];
      entry_nxt.lane[l].quo = '0;
      entry_nxt.lane[l].neg = in_side.comp[l][31];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
    st_r[0] <= entry_nxt;
  end

  for (genvar s = 0; s < N; s++) begin : g_step
    dv_stage_t st_nxt;

    always_comb begin
      logic [N:0] rs;
      logic       ge;
      st_nxt = st_r[s];
      for (int l = 0; l < 4; l++) begin
        rs = {st_r[s].lane[l].rem, st_r[s].lane[l].dlo[N-1]};
        ge = rs >= {1'b0, st_r[s].root};
        st_nxt.lane[l].rem = ge ? N'(rs - {1'b0, st_r[s].root}) : N'(rs);
        st_nxt.lane[l].quo = {st_r[s].lane[l].quo[N-2:0], ge};
        st_nxt.lane[l].dlo = {st_r[s].lane[l].dlo[N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
      st_r[s+1] <= st_nxt;
    end
  end

  function automatic logic [31:0] sat_quo(lane_t ln);
    logic [31:0] r;
    if (ln.neg) begin
      r = (ln.ovf || ln.quo > N'(33'h0_8000_0000)) ? 32'h8000_0000
                                                    : (~ln.quo[31:0] + 32'd1);
    end else begin
      r = (ln.ovf || ln.quo > N'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : ln.quo[31:0];
    end
    return r;
  endfunction

  dv_stage_t     fin;
  qvu_pkg::out_t res_nxt;
  logic          zero_root;
  logic [31:0]   mag_sat;
  logic          vld_out_r;
  logic [1:0]    func_out_r;
  qvu_pkg::out_t res_out_r;

  assign fin       = st_r[N];
  assign zero_root = (fin.root == '0);
  assign mag_sat   = fin.root[N-1] ? 32'hFFFF_FFFF : fin.root[31:0];

  always_comb begin
    res_nxt = '0;
    case (fin.func)
      qvu_pkg::FUNC_NORM_Q: begin
        if (zero_root) begin
          res_nxt.res_w = 32'(64'd1 << FRAC_BITS);
        end else begin
          res_nxt.res_x     = sat_quo(fin.lane[0]);
          res_nxt.res_y     = sat_quo(fin.lane[1]);
          res_nxt.res_z     = sat_quo(fin.lane[2]);
          res_nxt.res_w     = sat_quo(fin.lane[3]);
          res_nxt.magnitude = mag_sat;
        end
      end
      qvu_pkg::FUNC_NORM_V: begin
        res_nxt.magnitude = mag_sat;
        if (!zero_root) begin
          res_nxt.res_x = sat_quo(fin.lane[0]);
          res_nxt.res_y = sat_quo(fin.lane[1]);
          res_nxt.res_z = sat_quo(fin.lane[2]);
        end
      end
      qvu_pkg::FUNC_LENGTH: begin
        res_nxt.magnitude = mag_sat;
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out_r <= 1'b0;
    end else begin
      vld_out_r <= vld_r[N];
    end
    func_out_r <= fin.func;
    res_out_r  <= res_nxt;
  end

  assign out_valid = vld_out_r;
  assign out_func  = func_out_r;
  assign out_data  = res_out_r;

endmodule

// ===== rtl/quaternion_vector_unit.sv =====
// Top level of the quaternion vector unit.
//
// The unit takes one operation per cycle: rotate a vector by a quaternion,
// normalize a quaternion, normalize a vector, or give a vector's length, all
// in signed fixed point with FRAC_BITS fraction bits.
// An input transfer happens on a rising edge with start high and busy low;
// busy stays low, so a new item may follow in every cycle.
// Each result appears on out_data for one cycle with out_valid high, in
// input order, once its input has passed the two squaring stages, the
// 33-stage square root, the 35-stage divider and the output register;
// the rotate path is shorter and is delayed to line up.
// Throughput is one item per clock. The receiver cannot stall the unit, so
// results must be taken in the cycle they are shown.
// Synchronous reset clears all valid bits: items in flight are dropped and no
// result is shown until new items are accepted.
`timescale 1ns / 1ps
module quaternion_vector_unit #(
  parameter int FRAC_BITS = qvu_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  qvu_pkg::in_t  in_data,
  output logic          out_valid,
  output qvu_pkg::out_t out_data
);

  localparam int DLY = qvu_pkg::NORM_LAT - qvu_pkg::ROT_LAT;

  logic                            accept;
  qvu_pkg::norm_side_t             side_in;
  logic                            vld_a_r, vld_b_r;
  qvu_pkg::norm_side_t             side_a_r, side_b_r;
  logic [63:0]                     sq_a_r [4];
  logic [qvu_pkg::SUM_W-1:0]       sum_b_r;
  logic                            sq_valid;
  qvu_pkg::norm_side_t             sq_side;
  logic [qvu_pkg::ROOT_W-1:0]      sq_root;
  logic                            dv_valid;
  logic [1:0]                      dv_func;
  qvu_pkg::out_t                   dv_data;
  qvu_pkg::out_t                   rot_data;
  qvu_pkg::out_t                   rot_dly_r [DLY];
  logic                            out_valid_r;
  qvu_pkg::out_t                   out_data_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    side_in.func = in_data.func;
    if (in_data.func == qvu_pkg::FUNC_NORM_Q) begin
      side_in.comp = {in_data.quat_w, in_data.quat_z, in_data.quat_y, in_data.quat_x};
    end else begin
      side_in.comp = {32'd0, in_data.vec_z, in_data.vec_y, in_data.vec_x};
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_square
    logic [31:0] mag;
    assign mag = side_in.comp[l][31] ? 32'(~side_in.comp[l] + 32'd1) : side_in.comp[l];
    always_ff @(posedge clk) begin
      sq_a_r[l] <= mag * mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      vld_a_r <= accept;
      vld_b_r <= vld_a_r;
    end
    side_a_r <= side_in;
    side_b_r <= side_a_r;
    sum_b_r  <= qvu_pkg::SUM_W'(sq_a_r[0]) + qvu_pkg::SUM_W'(sq_a_r[1])
              + qvu_pkg::SUM_W'(sq_a_r[2]) + qvu_pkg::SUM_W'(sq_a_r[3]);
  end

  qvu_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_b_r),
    .in_side   (side_b_r),
    .in_sum    (sum_b_r),
    .out_valid (sq_valid),
    .out_side  (sq_side),
    .out_root  (sq_root)
  );

  qvu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_side   (sq_side),
    .in_root   (sq_root),
    .out_valid (dv_valid),
    .out_func  (dv_func),
    .out_data  (dv_data)
  );

  qvu_rot #(.FRAC_BITS(FRAC_BITS)) u_rot (
    .clk      (clk),
    .in_data  (in_data),
    .out_data (rot_data)
  );

  // Rotation results wait here until the norm path catches up.
  always_ff @(posedge clk) begin
    rot_dly_r[0] <= rot_data;
    for (int i = 1; i < DLY; i++) begin
      rot_dly_r[i] <= rot_dly_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_valid;
    end
    out_data_r <= (dv_func == qvu_pkg::FUNC_ROTATE) ? rot_dly_r[DLY-1] : dv_data;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/sv/quaternion_vector_unit_tb.sv =====
// Self-checking testbench of the quaternion vector unit.
`timescale 1ns / 1ps
module quaternion_vector_unit_tb;

  localparam int FB = qvu_pkg::FRAC_BITS_DEF;
  localparam int N_RANDOM = 1200;
  localparam int QUIET_TAIL = 200;
  localparam int DRAIN_CYCLES = qvu_pkg::NORM_LAT + 20;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  qvu_pkg::in_t  in_data;
  logic          out_valid;
  qvu_pkg::out_t out_data;

  qvu_pkg::out_t pending_results[$];
  int   mismatches;
  int   results_seen;
  int   items_sent;
  int   func_count[4];

  quaternion_vector_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d results still pending", pending_results.size());
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
    if (v > 128'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -128'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Exact floor square root, one result bit per pass.
  function automatic logic [32:0] floor_sqrt(logic [65:0] s);
    logic [32:0] root;
    logic [32:0] trial;
    root = '0;
    for (int b = 32; b >= 0; b--) begin
      trial = root | (33'd1 << b);
      if ({34'd0, trial} * {34'd0, trial} <= {1'b0, s}) root = trial;
    end
    return root;
  endfunction

  function automatic logic [63:0] abs64(logic signed [31:0] c);
    logic signed [63:0] e;
    e = c;
    return (e < 0) ? -e : e;
  endfunction

  // Quotient of a component by the norm, rounded toward zero and clamped.
  function automatic logic signed [31:0] scale_by_norm(logic signed [31:0] c,
                                                        logic [32:0] n);
    logic [63:0] q;
    q = (abs64(c) << FB) / {31'd0, n};
    if (c < 0) return (q > 64'h80000000) ? 32'sh80000000 : 32'(-q);
    return (q > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : q[31:0];
  endfunction

  function automatic qvu_pkg::out_t predict_result(qvu_pkg::in_t d);
    qvu_pkg::out_t r;
    logic signed [127:0] qa[4];
    logic signed [127:0] va[3];
    logic signed [127:0] ta[3];
    logic signed [127:0] acc;
    logic [65:0] sum;
    logic [32:0] n;
    int j, k;
    r = '0;
    qa[0] = d.quat_x; qa[1] = d.quat_y; qa[2] = d.quat_z; qa[3] = d.quat_w;
    va[0] = d.vec_x;  va[1] = d.vec_y;  va[2] = d.vec_z;
    case (d.func)
      qvu_pkg::FUNC_ROTATE: begin
        for (int i = 0; i < 3; i++) begin
          j = (i + 1) % 3;
          k = (i + 2) % 3;
          acc = qa[j] * va[k] - qa[k] * va[j] + qa[3] * va[i];
          acc = acc >>> FB;
          ta[i] = $signed(acc[63:0]);
        end
        for (int i = 0; i < 3; i++) begin
          j = (i + 1) % 3;
          k = (i + 2) % 3;
          acc = 2 * (qa[j] * ta[k] - qa[k] * ta[j]) + (va[i] <<< FB);
          acc = acc >>> FB;
          if (i == 0) r.res_x = clamp32(acc);
          else if (i == 1) r.res_y = clamp32(acc);
          else r.res_z = clamp32(acc);
        end
      end
      qvu_pkg::FUNC_NORM_Q: begin
        sum = 66'(abs64(d.quat_x) * abs64(d.quat_x)) + 66'(abs64(d.quat_y) * abs64(d.quat_y))
            + 66'(abs64(d.quat_z) * abs64(d.quat_z)) + 66'(abs64(d.quat_w) * abs64(d.quat_w));
        n = floor_sqrt(sum);
        if (n == 0) begin
          r.res_w = 32'sd1 <<< FB;
        end else begin
          r.res_x = scale_by_norm(d.quat_x, n);
          r.res_y = scale_by_norm(d.quat_y, n);
          r.res_z = scale_by_norm(d.quat_z, n);
          r.res_w = scale_by_norm(d.quat_w, n);
          r.magnitude = n[32] ? 32'hFFFFFFFF : n[31:0];
        end
      end
      default: begin
        sum = 66'(abs64(d.vec_x) * abs64(d.vec_x)) + 66'(abs64(d.vec_y) * abs64(d.vec_y))
            + 66'(abs64(d.vec_z) * abs64(d.vec_z));
        n = floor_sqrt(sum);
        r.magnitude = n[32] ? 32'hFFFFFFFF : n[31:0];
        if (d.func == qvu_pkg::FUNC_NORM_V && n != 0) begin
          r.res_x = scale_by_norm(d.vec_x, n);
          r.res_y = scale_by_norm(d.vec_y, n);
          r.res_z = scale_by_norm(d.vec_z, n);
        end
      end
    endcase
    return r;
  endfunction

  // Input side: every accepted transfer queues its predicted result.
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      pending_results.push_back(predict_result(in_data));
      func_count[in_data.func]++;
    end
  end

  // Result side: the unit cannot be stalled, so each strobe is checked at once.
  always @(posedge clk) begin
    qvu_pkg::out_t exp_r;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", out_data);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.res_x !== exp_r.res_x || out_data.res_y !== exp_r.res_y ||
            out_data.res_z !== exp_r.res_z || out_data.res_w !== exp_r.res_w ||
            out_data.magnitude !== exp_r.magnitude) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: x %h/%h y %h/%h z %h/%h w %h/%h mag %h/%h (exp/got)",
                     exp_r.res_x, out_data.res_x, exp_r.res_y, out_data.res_y,
                     exp_r.res_z, out_data.res_z, exp_r.res_w, out_data.res_w,
                     exp_r.magnitude, out_data.magnitude);
        end
      end
    end
  end

  typedef struct {
    qvu_pkg::in_t  item;
    bit            fixed;
    qvu_pkg::out_t result;
  } stim_row_t;

  function automatic logic signed [31:0] random_component();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      1, 2: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
      3: return $signed($urandom_range(0, 32'h1FFFFFF)) - 32'sh1000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic qvu_pkg::in_t random_item();
    qvu_pkg::in_t d;
    d.func   = 2'($urandom_range(0, 3));
    d.quat_x = random_component();
    d.quat_y = random_component();
    d.quat_z = random_component();
    d.quat_w = random_component();
    d.vec_x  = random_component();
    d.vec_y  = random_component();
    d.vec_z  = random_component();
    return d;
  endfunction

  task automatic send_item(qvu_pkg::in_t d, bit allow_gap);
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    qvu_pkg::out_t fixed_r;
    qvu_pkg::in_t d;
    int directed_errors;
    directed_errors = 0;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;

    // Zero quaternion gives the identity.
    row.item = '0; row.item.func = qvu_pkg::FUNC_NORM_Q;
    row.fixed = 1; row.result = '0; row.result.res_w = 32'sd1 <<< FB;
    rows.push_back(row);
    // Zero vector is returned unchanged.
    row.item = '0; row.item.func = qvu_pkg::FUNC_NORM_V; row.item.quat_w = 32'sh12345678;
    row.fixed = 1; row.result = '0;
    rows.push_back(row);
    // Largest quaternion: the norm overflows 32 bits.
    row.item = '0; row.item.func = qvu_pkg::FUNC_NORM_Q;
    row.item.quat_x = 32'sh80000000; row.item.quat_y = 32'sh80000000;
    row.item.quat_z = 32'sh80000000; row.item.quat_w = 32'sh80000000;
    row.fixed = 1; row.result = '{-32'sd32768, -32'sd32768, -32'sd32768, -32'sd32768,
                                  32'hFFFFFFFF};
    rows.push_back(row);
    // A 3-4-5 length leaves the components at zero.
    row.item = '0; row.item.func = qvu_pkg::FUNC_LENGTH;
    row.item.vec_x = 3; row.item.vec_y = -4;
    row.item.quat_x = -1;
    row.fixed = 1; row.result = '0; row.result.magnitude = 5;
    rows.push_back(row);
    // Identity rotation passes the vector through.
    row.item = '0; row.item.func = qvu_pkg::FUNC_ROTATE; row.item.quat_w = 32'sd1 <<< FB;
    row.item.vec_x = 32'sh7FFFFFFF; row.item.vec_y = 32'sh80000000; row.item.vec_z = 77;
    row.fixed = 1; row.result = '0;
    row.result.res_x = 32'sh7FFFFFFF; row.result.res_y = 32'sh80000000;
    row.result.res_z = 77;
    rows.push_back(row);
    row.fixed = 0;
    for (int f = 0; f < 4; f++) begin
      row.item.func = 2'(f);
      row.item.quat_x = 32'sh7FFFFFFF; row.item.quat_y = 32'sh80000000;
      row.item.quat_z = 32'sh7FFFFFFF; row.item.quat_w = 32'sh80000000;
      row.item.vec_x = 32'sh80000000; row.item.vec_y = 32'sh7FFFFFFF;
      row.item.vec_z = 32'sh80000000;
      rows.push_back(row);
      row.item.quat_x = 32'sh8000; row.item.quat_y = 0; row.item.quat_z = 0;
      row.item.quat_w = 32'sh0000B505;
      row.item.vec_x = 32'sh10000; row.item.vec_y = -32'sh20000; row.item.vec_z = 1;
      rows.push_back(row);
      row.item.quat_x = -1; row.item.quat_y = 1; row.item.quat_z = -1; row.item.quat_w = 1;
      row.item.vec_x = -1; row.item.vec_y = 0; row.item.vec_z = 0;
      rows.push_back(row);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].fixed) begin
        fixed_r = predict_result(rows[i].item);
        if (fixed_r != rows[i].result) begin
          directed_errors++;
          $display("Directed row %0d: hand-entered result %h, predictor %h",
                   i, rows[i].result, fixed_r);
        end
      end
      send_item(rows[i].item, 1'b0);
    end
    mismatches += directed_errors;

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) drain_results();
      d = random_item();
      send_item(d, i < N_RANDOM - QUIET_TAIL);
    end
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items (rotate %0d, quat norm %0d, vec norm %0d, length %0d)",
             items_sent, func_count[0], func_count[1], func_count[2], func_count[3]);
    $display("Checked %0d results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== quaternion_vector_unit.f =====
rtl/qvu_pkg.sv
rtl/qvu_rot.sv
rtl/qvu_sqrt.sv
rtl/qvu_div.sv
rtl/quaternion_vector_unit.sv
tb/sv/quaternion_vector_unit_tb.sv
